/* hw/rtl/ssfd_pkg.sv */
// shared types and constants for the sysex state frame decoder
package ssfd_pkg;

	localparam int TracksDef = 8;
	localparam int PayloadBytesDef = 17;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 8;

	localparam logic [7:0] SOX_BYTE = 8'hF0;
	localparam logic [7:0] EOX_BYTE = 8'hF7;

	localparam logic [CfgIdxW-1:0] REG_MANUFACTURER = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_MSG_TYPE     = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_COLOR_COUNT  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_LED_COUNT    = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_LOOPER_COUNT = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_PLAY_COUNT   = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_DEF_LOOPER   = 3'd6;

	// byte kinds as classified by the front end
	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_BODY   = 2'd1,
		KIND_LAST   = 2'd2
	} kind_t;

	// one classified byte handed from front end to back end
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;     // packed byte to unpack (body) or final byte (last)
		logic       take;     // body: data is a packed byte to process
		logic       hdr_err;  // last: header or sequencing error seen
		logic       short_msg;
		logic [1:0] version;
		logic [7:0] held;     // last: byte held back as checksum
	} item_t;

	// result record
	typedef struct packed {
		logic        frame_ok;
		logic [1:0]  version;
		logic [1:0]  mode_sel;
		logic [3:0]  flag_bits;
		logic [2:0]  loop_mode;
		logic [7:0]  colour_idx;
		logic        bank_sel;
		logic [7:0]  sel_track;
		logic [63:0] led_vec;
		logic [31:0] loop_length_us;
		logic [7:0]  gain_out;
	} result_t;

	typedef struct packed {
		logic [6:0] manufacturer_id;
		logic [6:0] message_type;
		logic [7:0] color_count;
		logic [7:0] led_count;
		logic [3:0] loop_mode_count;
		logic [2:0] mode_count;
		logic [2:0] default_loop_mode;
	} cfg_t;

endpackage

/* hw/rtl/ssfd_front.sv */
// front end: header checks, byte position and checksum hold-back
module ssfd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic [7:0]      byte_in,
	input  logic            last,
	input  ssfd_pkg::cfg_t  cfg,
	output ssfd_pkg::item_t item
);
	import ssfd_pkg::*;

	logic [5:0] pos_q;
	logic       err_q;
	logic [1:0] ver_q;
	logic [7:0] held_q;

	always_comb begin
		item = '0;
		item.version = ver_q;
		item.held = held_q;
		item.hdr_err = err_q;
		item.short_msg = (pos_q < 6'd6);
		item.data = byte_in;
		if (last) begin
			item.kind = KIND_LAST;
		end else if (pos_q < 6'd4) begin
			item.kind = KIND_HEADER;
		end else begin
			item.kind = KIND_BODY;
			item.take = (pos_q >= 6'd5);
			item.data = held_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			err_q <= 1'b0;
			ver_q <= '0;
			held_q <= '0;
		end else if (in_fire) begin
			if (last) begin
				pos_q <= '0;
				err_q <= 1'b0;
				ver_q <= '0;
				held_q <= '0;
			end else begin
				unique case (pos_q)
					6'd0: if (byte_in != SOX_BYTE) err_q <= 1'b1;
					6'd1: if (byte_in != {1'b0, cfg.manufacturer_id}) err_q <= 1'b1;
					6'd2: begin
						if (byte_in < 8'd1 || byte_in > 8'd3) err_q <= 1'b1;
						ver_q <= byte_in[1:0];
					end
					6'd3: if (byte_in != {1'b0, cfg.message_type}) err_q <= 1'b1;
					default: held_q <= byte_in;
				endcase
				if (pos_q != 6'd63) pos_q <= pos_q + 6'd1;
			end
		end
	end
endmodule

/* hw/rtl/ssfd_fifo.sv */
// short queue of classified items between front and back end
module ssfd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ssfd_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output ssfd_pkg::item_t pop_item
);
	import ssfd_pkg::*;

	item_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue overrun");
	assert property (@(posedge clk) disable iff (!arst_n) !not_empty |-> !pop)
		else $error("queue underrun");
endmodule

/* hw/rtl/ssfd_back.sv */
// back end: xor checksum, 7-bit unpacking, payload store and final checks
module ssfd_back #(
	parameter int Tracks = ssfd_pkg::TracksDef,
	parameter int PayloadBytes = ssfd_pkg::PayloadBytesDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  ssfd_pkg::item_t   item,
	input  ssfd_pkg::cfg_t    cfg,
	input  logic              res_stall,
	output logic              res_valid,
	output ssfd_pkg::result_t res
);
	import ssfd_pkg::*;

	localparam int CntW = $clog2(PayloadBytes + 1);
	localparam int IdxW = $clog2(PayloadBytes);

	logic [7:0]      xor_q;
	logic [6:0]      hib_q;
	logic [2:0]      gidx_q;
	logic [CntW-1:0] cnt_q;
	logic            err_q;
	logic [7:0]      store_q [PayloadBytes];

	logic [7:0] unp;
	assign unp = {hib_q[gidx_q - 3'd1], item.data[6:0]};

	always_ff @(posedge clk) begin
		if (go && item.kind == KIND_BODY && item.take && gidx_q != 3'd0 &&
		    cnt_q < CntW'(PayloadBytes))
			store_q[cnt_q[IdxW-1:0]] <= unp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_q <= '0;
			hib_q <= '0;
			gidx_q <= '0;
			cnt_q <= '0;
			err_q <= 1'b0;
		end else if (go) begin
			if (item.kind == KIND_LAST) begin
				xor_q <= '0;
				hib_q <= '0;
				gidx_q <= '0;
				cnt_q <= '0;
				err_q <= 1'b0;
			end else if (item.kind == KIND_BODY && item.take) begin
				xor_q <= xor_q ^ item.data;
				if (item.data[7]) err_q <= 1'b1;
				if (gidx_q == 3'd0) begin
					hib_q <= item.data[6:0];
					gidx_q <= 3'd1;
				end else begin
					if (cnt_q < CntW'(PayloadBytes)) cnt_q <= cnt_q + CntW'(1);
					else err_q <= 1'b1;
					gidx_q <= (gidx_q == 3'd7) ? 3'd0 : gidx_q + 3'd1;
				end
			end
		end
	end

	// final checks on the last byte
	logic       ok;
	logic       v2;
	logic [2:0] looper;
	logic [1:0] mode;
	logic [63:0] leds;
	result_t    res_d;
	always_comb begin
		v2 = (item.version >= 2'd2);
		looper = store_q[0][6:4];
		mode = {store_q[2][1], store_q[0][0]};
		ok = !(item.hdr_err || err_q || item.short_msg || item.data != EOX_BYTE);
		if ({1'b0, xor_q[6:0]} != item.held) ok = 1'b0;
		if (cnt_q != CntW'(PayloadBytes) && cnt_q != CntW'(PayloadBytes - 1)) ok = 1'b0;
		if (store_q[1] >= cfg.color_count) ok = 1'b0;
		if (item.version == 2'd3 ? store_q[2] > 8'd3 : store_q[2] > 8'd1) ok = 1'b0;
		if (store_q[3] >= 8'(Tracks)) ok = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (store_q[4 + i] >= cfg.led_count) ok = 1'b0;
			leds[8*i +: 8] = store_q[4 + i];
		end
		if (v2 && {1'b0, looper} >= cfg.loop_mode_count) ok = 1'b0;
		if ({1'b0, mode} >= cfg.mode_count) ok = 1'b0;
	end

	// rejected frames carry all-zero fields
	always_comb begin
		res_d = '0;
		if (ok) begin
			res_d.frame_ok = 1'b1;
			res_d.version = item.version;
			res_d.mode_sel = mode;
			res_d.flag_bits = {v2 & store_q[0][7], store_q[0][3:1]};
			res_d.loop_mode = v2 ? looper : cfg.default_loop_mode;
			res_d.colour_idx = store_q[1];
			res_d.bank_sel = store_q[2][0];
			res_d.sel_track = store_q[3];
			res_d.led_vec = leds;
			res_d.loop_length_us = {store_q[15], store_q[14], store_q[13], store_q[12]};
			res_d.gain_out = (cnt_q == CntW'(PayloadBytes)) ? store_q[16] : 8'd255;
		end
	end

	// result register doubles as the output stage and holds while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid <= 1'b0;
		else if (go && item.kind == KIND_LAST) res_valid <= 1'b1;
		else if (!res_stall) res_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (go && item.kind == KIND_LAST) res <= res_d;
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CntW'(PayloadBytes))
		else $error("payload count beyond store");
	assert property (@(posedge clk) disable iff (!arst_n)
		go && item.kind == KIND_LAST |=> gidx_q == 3'd0 && cnt_q == '0)
		else $error("unpack state not cleared after message end");
	assert property (@(posedge clk) disable iff (!arst_n)
		go && item.kind == KIND_BODY && item.take && gidx_q == 3'd0 |=> gidx_q == 3'd1)
		else $error("high-bit byte did not open a group");
endmodule

/* hw/rtl/sysex_state_frame_decoder.sv */
// top level of the sysex state frame decoder
// the byte with last set passes through the queue and then the back end's result register, which presents the result
// throughput: one byte per cycle while in_stall is low; header and body bytes never hold the back end
// only a byte with last set yields a result; other bytes yield none
// a result held by out_stall keeps the next last byte at the queue head; in_stall rises after one more byte
// reset clears all control state and loads register reset values; store is unset until written
module sysex_state_frame_decoder #(
	parameter int Tracks = ssfd_pkg::TracksDef,
	parameter int PayloadBytes = ssfd_pkg::PayloadBytesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_in,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        frame_ok,
	output logic [1:0]  version,
	output logic [1:0]  mode_sel,
	output logic [3:0]  flag_bits,
	output logic [2:0]  loop_mode,
	output logic [7:0]  colour_idx,
	output logic        bank_sel,
	output logic [7:0]  sel_track,
	output logic [63:0] led_vec,
	output logic [31:0] loop_length_us,
	output logic [7:0]  gain_out,
	input  logic        cfg_we,
	input  logic [ssfd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [ssfd_pkg::CfgDataW-1:0] cfg_data
);
	import ssfd_pkg::*;

	cfg_t    cfg_q;
	item_t   f_item, q_item;
	logic    q_full, q_ne, in_fire, go;
	logic    res_valid;
	result_t res;

	// configuration registers, masked to width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.manufacturer_id <= 7'd125;
			cfg_q.message_type <= 7'd1;
			cfg_q.color_count <= 8'd8;
			cfg_q.led_count <= 8'd4;
			cfg_q.loop_mode_count <= 4'd5;
			cfg_q.mode_count <= 3'd3;
			cfg_q.default_loop_mode <= 3'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MANUFACTURER: cfg_q.manufacturer_id <= cfg_data[6:0];
				REG_MSG_TYPE:     cfg_q.message_type <= cfg_data[6:0];
				REG_COLOR_COUNT:  cfg_q.color_count <= cfg_data;
				REG_LED_COUNT:    cfg_q.led_count <= cfg_data;
				REG_LOOPER_COUNT: cfg_q.loop_mode_count <= cfg_data[3:0];
				REG_PLAY_COUNT:   cfg_q.mode_count <= cfg_data[2:0];
				REG_DEF_LOOPER:   cfg_q.default_loop_mode <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// front end takes a byte whenever the queue has room
	assign in_stall = q_full;
	assign in_fire = in_valid && !in_stall;

	ssfd_front u_front (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .byte_in(byte_in),
		.last(last), .cfg(cfg_q), .item(f_item)
	);

	ssfd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(in_fire), .push_item(f_item), .full(q_full),
		.pop(go), .not_empty(q_ne), .pop_item(q_item)
	);

	// back end moves unless a last item meets a result that is still stalled;
	// header and body items never block
	assign go = q_ne && !(q_item.kind == KIND_LAST && res_valid && out_stall);

	ssfd_back #(.Tracks(Tracks), .PayloadBytes(PayloadBytes)) u_back (
		.clk(clk), .arst_n(arst_n), .go(go), .item(q_item), .cfg(cfg_q),
		.res_stall(out_stall), .res_valid(res_valid), .res(res)
	);

	// the back end's result register is the output stage
	assign out_valid = res_valid;
	assign frame_ok = res.frame_ok;
	assign version = res.version;
	assign mode_sel = res.mode_sel;
	assign flag_bits = res.flag_bits;
	assign loop_mode = res.loop_mode;
	assign colour_idx = res.colour_idx;
	assign bank_sel = res.bank_sel;
	assign sel_track = res.sel_track;
	assign led_vec = res.led_vec;
	assign loop_length_us = res.loop_length_us;
	assign gain_out = res.gain_out;

	assert property (@(posedge clk) disable iff (!arst_n)
		go && q_item.kind == KIND_LAST |-> !out_valid || !out_stall)
		else $error("result would overwrite a waiting transfer");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(res))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_ok |-> gain_out == 8'd0 && led_vec == 64'd0)
		else $error("rejected frame with non-zero fields");
endmodule
